// ===== rtl/dmtt_pkg.sv =====
// Shared types and constants of the transposition table.
`default_nettype none
package dmtt_pkg;

  typedef enum logic [1:0] {
    ACT_PROBE  = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_OCCUPY = 2'd3
  } act_t;

  // One queued request, as classified by the front part.
  typedef struct packed {
    act_t        action;
    logic [63:0] key;
    logic [15:0] score;
    logic [15:0] depth;
    logic [7:0]  flag;
    logic [15:0] move;
  } dmtt_item_t;

  // One table slot; all zeros is an empty slot.
  typedef struct packed {
    logic [63:0] key;
    logic [7:0]  gen;
    logic [15:0] score;
    logic [15:0] depth;
    logic [7:0]  flag;
    logic [15:0] move;
  } dmtt_entry_t;

  localparam int HASH_SHIFT  = 32;
  localparam int DEPTH_SLACK = 2;
  localparam int PERMILLE    = 1000;
  localparam int OCC_W       = 10;
  localparam int PROD_W      = 20;
  localparam int QDEPTH      = 2;

endpackage
`default_nettype wire

// ===== rtl/dmtt_div.sv =====
// Occupancy scaling: count * 1000 / SAMPLE_SIZE by reciprocal multiplication; product and quotient are registered.
`default_nettype none
module dmtt_div import dmtt_pkg::*; #(
  parameter int SAMPLE_SIZE = 1000
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [OCC_W-1:0] count,
  output logic                  done,
  output logic [OCC_W-1:0]      quotient
);

  localparam int RECIP_SHIFT = PROD_W + $clog2(SAMPLE_SIZE);
  localparam int RECIP_W     = PROD_W + 2;
  localparam int WIDE_W      = PROD_W + RECIP_W;
  // ceil(2**RECIP_SHIFT / SAMPLE_SIZE): exact for every product below 2**PROD_W
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SAMPLE_SIZE) - 64'd1) / 64'(SAMPLE_SIZE));
  localparam logic [PROD_W-1:0] PROD_MUL = PROD_W'(PERMILLE);

  logic [PROD_W-1:0] prod;
  logic [WIDE_W-1:0] scaled;
  logic              prod_valid;

  assign scaled = WIDE_W'(prod) * WIDE_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= start;
      done       <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // count never exceeds SAMPLE_SIZE, so the product fits in PROD_W bits
      prod <= PROD_W'(count) * PROD_MUL;
    end
    if (prod_valid) begin
      quotient <= scaled[RECIP_SHIFT +: OCC_W];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dmtt_front.sv =====
// Front part: accepts requests, computes the slot index and queues them.
`default_nettype none
module dmtt_front import dmtt_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            action,
  input  wire logic [63:0]           key,
  input  wire logic signed [15:0]    score,
  input  wire logic signed [15:0]    search_depth,
  input  wire logic [7:0]            bound_flag,
  input  wire logic [15:0]           best_move,
  input  wire logic                  init_busy,
  output logic                       q_valid,
  output dmtt_item_t                 q_item,
  output logic [INDEX_BITS-1:0]      q_index,
  input  wire logic                  q_pop
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  dmtt_item_t            items [QDEPTH];
  logic [INDEX_BITS-1:0] idxs  [QDEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  push;
  logic                  pop;
  dmtt_item_t            new_item;
  logic [INDEX_BITS-1:0] new_index;

  assign in_stall = (count == CNT_W'(QDEPTH)) || init_busy;
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = count != '0;
  assign q_item   = items[rd_ptr];
  assign q_index  = idxs[rd_ptr];

  always_comb begin
    new_item.action = act_t'(action);
    new_item.key    = key;
    new_item.score  = score;
    new_item.depth  = search_depth;
    new_item.flag   = bound_flag;
    new_item.move   = best_move;
    new_index       = key[INDEX_BITS-1:0] ^ key[HASH_SHIFT +: INDEX_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      items[wr_ptr] <= new_item;
      idxs[wr_ptr]  <= new_index;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dmtt_back.sv =====
// Back part: slot memory, request sequencer, sweeps and result register.
`default_nettype none
module dmtt_back import dmtt_pkg::*; #(
  parameter int INDEX_BITS  = 16,
  parameter int SAMPLE_SIZE = 1000
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire dmtt_item_t         q_item,
  input  wire logic [INDEX_BITS-1:0] q_index,
  output logic                    q_pop,
  output logic                    init_busy,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    hit,
  output logic [15:0]             found_move,
  output logic signed [15:0]      stored_score,
  output logic signed [15:0]      stored_depth,
  output logic [7:0]              stored_flag,
  output logic [OCC_W-1:0]        occupancy_permille
);

  localparam int SLOTS = 1 << INDEX_BITS;
  localparam int SCW   = $clog2(SAMPLE_SIZE + 1);

  typedef enum logic [5:0] {
    S_SWEEP    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_EXEC     = 6'b000100,
    S_OCC_SCAN = 6'b001000,
    S_OCC_DIV  = 6'b010000,
    S_OCC_OUT  = 6'b100000
  } state_t;

  dmtt_entry_t mem [SLOTS];
  dmtt_entry_t rdata;

  state_t                state;
  state_t                state_next;
  dmtt_item_t            cur;
  logic [INDEX_BITS-1:0] sweep_idx;
  logic [SCW-1:0]        scan_issue;
  logic                  rd_pend;
  logic [OCC_W-1:0]      occ_count;
  logic [7:0]            generation;

  logic                  mem_re;
  logic [INDEX_BITS-1:0] mem_raddr;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  dmtt_entry_t           mem_wdata;

  logic                  out_free;
  logic                  load_probe;
  logic                  load_occ;
  logic                  replace;
  logic                  div_start;
  logic                  div_done;
  logic [OCC_W-1:0]      div_quo;
  logic signed [16:0]    new_depth_ext;
  logic signed [16:0]    old_depth_ext;
  dmtt_entry_t           new_entry;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    new_depth_ext = $signed({cur.depth[15], cur.depth}) + 17'(DEPTH_SLACK);
    old_depth_ext = $signed({rdata.depth[15], rdata.depth});
    replace = (rdata.key == '0) || (new_depth_ext >= old_depth_ext) ||
              (rdata.gen != generation);
    new_entry.key   = cur.key;
    new_entry.gen   = generation;
    new_entry.score = cur.score;
    new_entry.depth = cur.depth;
    new_entry.flag  = cur.flag;
    new_entry.move  = cur.move;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = q_index;
    mem_we     = 1'b0;
    mem_waddr  = sweep_idx;
    mem_wdata  = '0;
    load_probe = 1'b0;
    load_occ   = 1'b0;
    div_start  = 1'b0;
    case (state)
      S_SWEEP: begin
        mem_we = 1'b1;
        if (&sweep_idx) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.action)
            ACT_PROBE, ACT_STORE: begin
              mem_re     = 1'b1;
              state_next = S_EXEC;
            end
            ACT_CLEAR:  state_next = S_SWEEP;
            ACT_OCCUPY: state_next = S_OCC_SCAN;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_EXEC: begin
        if (cur.action == ACT_STORE) begin
          mem_we     = replace;
          mem_waddr  = cur.key[INDEX_BITS-1:0] ^ cur.key[HASH_SHIFT +: INDEX_BITS];
          mem_wdata  = new_entry;
          state_next = S_IDLE;
        end else if (out_free) begin
          load_probe = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_OCC_SCAN: begin
        mem_raddr = INDEX_BITS'(scan_issue);
        if (scan_issue != SCW'(SAMPLE_SIZE)) begin
          mem_re = 1'b1;
        end else if (!rd_pend) begin
          div_start  = 1'b1;
          state_next = S_OCC_DIV;
        end
      end
      S_OCC_DIV: begin
        if (div_done) begin
          state_next = S_OCC_OUT;
        end
      end
      S_OCC_OUT: begin
        if (out_free) begin
          load_occ   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      init_busy  <= 1'b1;
      sweep_idx  <= '0;
      generation <= '0;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        generation <= cfg_data;
      end
      if (state == S_SWEEP) begin
        sweep_idx <= sweep_idx + 1'b1;
        if (&sweep_idx) begin
          init_busy <= 1'b0;
        end
      end
      rd_pend <= (state == S_OCC_SCAN) && mem_re;
      if (load_probe || load_occ) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sweep_idx wraps to zero at the end of each sweep
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur        <= q_item;
      scan_issue <= '0;
      occ_count  <= '0;
    end
    if (state == S_OCC_SCAN) begin
      scan_issue <= scan_issue + SCW'(mem_re);
      if (rd_pend && rdata.key != '0) begin
        occ_count <= occ_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_probe) begin
      hit                <= rdata.key == cur.key;
      found_move         <= (rdata.key == cur.key) ? rdata.move : 16'd0;
      stored_score       <= rdata.score;
      stored_depth       <= rdata.depth;
      stored_flag        <= rdata.flag;
      occupancy_permille <= '0;
    end else if (load_occ) begin
      hit                <= 1'b0;
      found_move         <= '0;
      stored_score       <= '0;
      stored_depth       <= '0;
      stored_flag        <= '0;
      occupancy_permille <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  dmtt_div #(
    .SAMPLE_SIZE(SAMPLE_SIZE)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .count   (occ_count),
    .done    (div_done),
    .quotient(div_quo)
  );

endmodule
`default_nettype wire

// ===== rtl/direct_mapped_transposition_table.sv =====
// Top level of the direct-mapped transposition table.
//
// Direct-mapped table of 2**INDEX_BITS search entries in one single-port-write
// synchronous memory; slot = low INDEX_BITS of key ^ (key >> 32). Requests go
// into a two-entry queue, so the input side keeps taking items while a result
// waits at the output. In the back part a probe or a store first reads the
// slot, then compares and, for a store, writes back. A clear writes one slot
// per cycle through all 2**INDEX_BITS slots. An occupancy query reads the first
// SAMPLE_SIZE slots, one per cycle, then scales by 1000 / SAMPLE_SIZE with a
// registered reciprocal multiplication. After reset the table is zeroed by a
// clearing pass during which in_stall is high; generation writes are taken at
// all times and should only be made while no item is in flight.
`default_nettype none
module direct_mapped_transposition_table import dmtt_pkg::*; #(
  parameter int INDEX_BITS  = 16,
  parameter int SAMPLE_SIZE = 1000
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic [63:0]        key,
  input  wire logic signed [15:0] score,
  input  wire logic signed [15:0] search_depth,
  input  wire logic [7:0]         bound_flag,
  input  wire logic [15:0]        best_move,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    hit,
  output logic [15:0]             found_move,
  output logic signed [15:0]      stored_score,
  output logic signed [15:0]      stored_depth,
  output logic [7:0]              stored_flag,
  output logic [9:0]              occupancy_permille
);

  logic                  q_valid;
  dmtt_item_t            q_item;
  logic [INDEX_BITS-1:0] q_index;
  logic                  q_pop;
  logic                  init_busy;

  dmtt_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .key         (key),
    .score       (score),
    .search_depth(search_depth),
    .bound_flag  (bound_flag),
    .best_move   (best_move),
    .init_busy   (init_busy),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_index     (q_index),
    .q_pop       (q_pop)
  );

  dmtt_back #(
    .INDEX_BITS (INDEX_BITS),
    .SAMPLE_SIZE(SAMPLE_SIZE)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_index           (q_index),
    .q_pop             (q_pop),
    .init_busy         (init_busy),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .hit               (hit),
    .found_move        (found_move),
    .stored_score      (stored_score),
    .stored_depth      (stored_depth),
    .stored_flag       (stored_flag),
    .occupancy_permille(occupancy_permille)
  );

endmodule
`default_nettype wire

// ===== rtl/dmtt_checker.sv =====
// Port-level checks of the transposition table, bound to the top level.
`default_nettype none
module dmtt_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [1:0]         action,
  input wire logic [63:0]        key,
  input wire logic signed [15:0] score,
  input wire logic signed [15:0] search_depth,
  input wire logic [7:0]         bound_flag,
  input wire logic [15:0]        best_move,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic [7:0]         cfg_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               hit,
  input wire logic [15:0]        found_move,
  input wire logic signed [15:0] stored_score,
  input wire logic signed [15:0] stored_depth,
  input wire logic [7:0]         stored_flag,
  input wire logic [9:0]         occupancy_permille
);

  // table is being zeroed right after reset
  a_init_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during clearing pass");

  a_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hit) && $stable(found_move) &&
      $stable(stored_score) && $stable(occupancy_permille)))
    else $error("stalled result changed");

  a_move_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found_move != 16'd0) |-> hit)
    else $error("move reported on a miss");

  a_hit_no_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> occupancy_permille == 10'd0)
    else $error("probe result carries occupancy");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy_permille <= 10'd1000)
    else $error("occupancy above 1000");

endmodule

bind direct_mapped_transposition_table dmtt_checker u_dmtt_checker (.*);
`default_nettype wire

// ===== test/dmtt_checker.sv =====
// Watches the table's channels, tracks slot contents and checks every result item.
`timescale 1ns / 1ps
module dmtt_scoreboard import dmtt_pkg::*; #(
  parameter int INDEX_BITS  = 16,
  parameter int SAMPLE_SIZE = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] key,
  input  logic [15:0] score,
  input  logic [15:0] search_depth,
  input  logic [7:0]  bound_flag,
  input  logic [15:0] best_move,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        hit,
  input  logic [15:0] found_move,
  input  logic [15:0] stored_score,
  input  logic [15:0] stored_depth,
  input  logic [7:0]  stored_flag,
  input  logic [9:0]  occupancy_permille,
  output int          fail_count,
  output int          results_due
);

  typedef struct packed {
    logic        hit;
    logic [15:0] move;
    logic [15:0] score;
    logic [15:0] depth;
    logic [7:0]  flag;
    logic [9:0]  occ;
  } answer_t;

  // Sparse copy of the table: a missing slot reads as all zeros.
  dmtt_entry_t slot_entries[int];
  logic [7:0]  cur_gen;
  answer_t     answers_due[$];

  initial begin
    fail_count  = 0;
    results_due = 0;
  end

  function automatic int slot_index(logic [63:0] k);
    logic [63:0] mixed;
    mixed = k ^ (k >> HASH_SHIFT);
    return int'(mixed[INDEX_BITS-1:0]);
  endfunction

  function automatic dmtt_entry_t read_slot(int i);
    if (slot_entries.exists(i)) return slot_entries[i];
    return '0;
  endfunction

  function automatic answer_t probe_answer(logic [63:0] k);
    dmtt_entry_t e;
    answer_t a;
    e = read_slot(slot_index(k));
    a = '0;
    a.hit   = (e.key == k);
    a.move  = a.hit ? e.move : 16'd0;
    a.score = e.score;
    a.depth = e.depth;
    a.flag  = e.flag;
    return a;
  endfunction

  function automatic void store_entry(logic [63:0] k, logic [15:0] sc, logic [15:0] dp,
                                      logic [7:0] fl, logic [15:0] mv);
    int i;
    int fresh_depth;
    int held_depth;
    dmtt_entry_t old;
    i = slot_index(k);
    old = read_slot(i);
    fresh_depth = $signed(dp);
    held_depth  = $signed(old.depth);
    // empty slot, deep enough, or left over from an older search
    if (old.key == '0 || fresh_depth + DEPTH_SLACK >= held_depth || old.gen != cur_gen) begin
      slot_entries[i] = '{key: k, gen: cur_gen, score: sc, depth: dp, flag: fl, move: mv};
    end
  endfunction

  function automatic answer_t occupancy_answer();
    int filled;
    answer_t a;
    filled = 0;
    for (int i = 0; i < SAMPLE_SIZE; i++) begin
      if (read_slot(i).key != '0) filled++;
    end
    a = '0;
    a.occ = 10'(filled * PERMILLE / SAMPLE_SIZE);
    return a;
  endfunction

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    if (rst) begin
      slot_entries.delete();
      answers_due.delete();
      cur_gen = '0;
      results_due <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cur_gen = cfg_data;

      if (out_valid && !out_stall) begin
        got.hit   = hit;
        got.move  = found_move;
        got.score = stored_score;
        got.depth = stored_depth;
        got.flag  = stored_flag;
        got.occ   = occupancy_permille;
        if (answers_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result item with nothing outstanding: hit=%b move=%h occ=%0d",
                     $realtime, got.hit, got.move, got.occ);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (got.hit !== want.hit || got.move !== want.move || got.score !== want.score ||
              got.depth !== want.depth || got.flag !== want.flag || got.occ !== want.occ) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch expected hit=%b move=%h score=%0d depth=%0d flag=%h occ=%0d",
                       $realtime, want.hit, want.move, $signed(want.score),
                       $signed(want.depth), want.flag, want.occ);
              $display("%0t:          actual   hit=%b move=%h score=%0d depth=%0d flag=%h occ=%0d",
                       $realtime, got.hit, got.move, $signed(got.score),
                       $signed(got.depth), got.flag, got.occ);
            end
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        case (act_t'(action))
          ACT_PROBE:  answers_due.push_back(probe_answer(key));
          ACT_STORE:  store_entry(key, score, search_depth, bound_flag, best_move);
          ACT_CLEAR:  slot_entries.delete();
          ACT_OCCUPY: answers_due.push_back(occupancy_answer());
          default:    ;
        endcase
      end

      results_due <= answers_due.size();
    end
  end

endmodule

// ===== test/direct_mapped_transposition_table_test.sv =====
// Stimulus and verdict for the transposition table, checked by dmtt_scoreboard.
`timescale 1ns / 1ps
module direct_mapped_transposition_table_test;
  import dmtt_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic [1:0]         action = ACT_PROBE;
  logic [63:0]        key = '0;
  logic signed [15:0] score = '0;
  logic signed [15:0] search_depth = '0;
  logic [7:0]         bound_flag = '0;
  logic [15:0]        best_move = '0;
  logic               cfg_valid = 1'b0;
  logic [7:0]         cfg_data = '0;
  logic               out_stall = 1'b0;

  wire                in_stall;
  wire                cfg_ready;
  wire                out_valid;
  wire                hit;
  wire [15:0]         found_move;
  wire signed [15:0]  stored_score;
  wire signed [15:0]  stored_depth;
  wire [7:0]          stored_flag;
  wire [9:0]          occupancy_permille;

  int                 fail_count;
  int                 results_due;
  int                 gap_pct = 0;
  int                 stall_pct = 0;
  logic [63:0]        recent_keys[$];

  direct_mapped_transposition_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key(key), .score(score), .search_depth(search_depth),
    .bound_flag(bound_flag), .best_move(best_move),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .found_move(found_move), .stored_score(stored_score),
    .stored_depth(stored_depth), .stored_flag(stored_flag),
    .occupancy_permille(occupancy_permille)
  );

  dmtt_scoreboard u_scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key(key), .score(score), .search_depth(search_depth),
    .bound_flag(bound_flag), .best_move(best_move),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .found_move(found_move), .stored_score(stored_score),
    .stored_depth(stored_depth), .stored_flag(stored_flag),
    .occupancy_permille(occupancy_permille),
    .fail_count(fail_count), .results_due(results_due)
  );

  always #2 clk = ~clk;

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Key that hashes to the given slot, random everywhere else.
  function automatic logic [63:0] key_at(int idx);
    logic [31:0] upper;
    logic [15:0] middle;
    upper  = $urandom;
    middle = 16'($urandom_range(16'hFFFF));
    return {upper, middle, 16'(idx) ^ upper[15:0]};
  endfunction

  task automatic offer(act_t a, logic [63:0] k, logic [15:0] sc, logic [15:0] dp,
                       logic [7:0] fl, logic [15:0] mv);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid     <= 1'b1;
    action       <= a;
    key          <= k;
    score        <= sc;
    search_depth <= dp;
    bound_flag   <= fl;
    best_move    <= mv;
    do @(posedge clk); while (in_stall);
    if (a == ACT_STORE) begin
      recent_keys.push_back(k);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
  endtask

  task automatic probe(logic [63:0] k);
    offer(ACT_PROBE, k, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // A trailing probe marks the point where every earlier item has been worked off.
  task automatic settle();
    probe({$urandom, $urandom});
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_generation(logic [7:0] g);
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      1:       begin gap_pct = 61; stall_pct <= 0;  end
      2:       begin gap_pct = 0;  stall_pct <= 61; end
      3:       begin gap_pct = 11; stall_pct <= 11; end
      default: begin gap_pct = 0;  stall_pct <= 0;  end
    endcase
  endtask

  function automatic logic [63:0] pick_known();
    if (recent_keys.size() == 0) return key_at($urandom_range(1199));
    return recent_keys[$urandom_range(recent_keys.size() - 1)];
  endfunction

  task automatic random_item();
    int          pick;
    int          sub;
    logic [63:0] k;
    logic [15:0] dp;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    if (pick < 4) begin
      offer(ACT_OCCUPY, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
            8'($urandom), 16'($urandom));
    end else if (pick < 50) begin
      if (sub < 55)      k = pick_known();
      else if (sub < 80) k = key_at($urandom_range(1199));
      else if (sub < 95) k = {$urandom, $urandom};
      else               k = '0;
      probe(k);
    end else begin
      if (sub < 35)      k = pick_known();
      else if (sub < 90) k = key_at($urandom_range(1199));
      else if (sub < 97) k = {$urandom, $urandom};
      else               k = '0;
      // mostly shallow depths so replacement goes both ways
      if ($urandom_range(99) < 80) dp = 16'($urandom_range(48)) - 16'd8;
      else                         dp = 16'($urandom);
      offer(ACT_STORE, k, 16'($urandom), dp, 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [63:0] ka;
    logic [63:0] kb;
    logic [63:0] kc;
    logic [63:0] kd;
    logic [7:0]  gens[5];

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    ka = key_at(5);
    kb = key_at(5);
    kc = key_at(9);
    kd = key_at(9);

    set_idling(0);
    write_generation(8'd0);
    probe(64'd0);                         // empty slot, key zero: a hit with move 0
    probe(64'hFFFF_FFFF_FFFF_FFFF);       // same slot as key zero, miss
    offer(ACT_STORE, ka, 16'sh8000, 16'sh7FFF, 8'hFF, 16'hFFFF);
    probe(ka);
    offer(ACT_STORE, kb, 16'sh7FFF, 16'sh8000, 8'h00, 16'h0001); // too shallow
    probe(kb);
    offer(ACT_STORE, ka, 16'sd1, 16'sd32765, 8'h01, 16'h1234);   // exactly at slack
    offer(ACT_STORE, kb, 16'sd2, 16'sd32762, 8'h02, 16'h4321);   // one short
    probe(ka);
    offer(ACT_STORE, 64'd0, 16'sd3, 16'sd3, 8'h5A, 16'hBEEF);    // slot stays empty
    probe(64'd0);
    offer(ACT_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 16'sd4, 16'sd0, 8'hA5, 16'h0F0F);
    offer(ACT_STORE, kc, 16'sd5, 16'sh7FFF, 8'h33, 16'h5555);
    offer(ACT_OCCUPY, '0, '0, '0, '0, '0);
    offer(ACT_CLEAR, '1, '1, '1, '1, '1);
    probe(ka);
    offer(ACT_OCCUPY, '1, '1, '1, '1, '1);
    offer(ACT_STORE, kc, 16'sd6, 16'sh7FFF, 8'h44, 16'hAAAA);
    settle();

    gens = '{8'd255, 8'd1, 8'd128, 8'd0, 8'($urandom)};
    for (int phase = 1; phase <= 5; phase++) begin
      write_generation(gens[phase-1]);
      set_idling((phase - 1) % 4);
      if (phase == 1) begin
        // deep entry from the previous search gives way to a shallow one
        offer(ACT_STORE, kd, 16'sd7, 16'sh8000, 8'h77, 16'h7777);
        probe(kd);
      end
      for (int n = 0; n < 140; n++) begin
        if (phase == 3 && n == 70)
          offer(ACT_CLEAR, {$urandom, $urandom}, '0, '0, '0, '0);
        else
          random_item();
      end
      settle();
    end

    if (fail_count == 0 && results_due == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
